// ===== rtl/core/akrc_pkg.sv =====
// Package for the accelerating key repeat counter.
// Widths, register indexes, reset values, the step and segment functions.
// No dependencies.
package akrc_pkg;

	localparam int COUNT_MODULUS = 100;

	localparam int VALUE_W    = 7;
	localparam int PERIOD_W   = 7;
	localparam int REPEATS_W  = 3;
	localparam int DIGIT_W    = 4;
	localparam int SEG_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(COUNT_MODULUS - 1);

	localparam logic [PERIOD_W-1:0]  FIRST_DELAY_RST  = PERIOD_W'(30);
	localparam logic [PERIOD_W-1:0]  SLOW_PERIOD_RST  = PERIOD_W'(100);
	localparam logic [REPEATS_W-1:0] SLOW_REPEATS_RST = REPEATS_W'(5);
	localparam logic [PERIOD_W-1:0]  FAST_PERIOD_RST  = PERIOD_W'(10);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_DELAY,
		REG_SLOW_PERIOD,
		REG_SLOW_REPEATS,
		REG_FAST_PERIOD
	} cfg_reg_t;

	typedef struct packed {
		logic [PERIOD_W-1:0]  first_delay;
		logic [PERIOD_W-1:0]  slow_period;
		logic [REPEATS_W-1:0] slow_repeats;
		logic [PERIOD_W-1:0]  fast_period;
	} cfg_t;

	// modulo step, out-of-range values are treated as zero before the step
	function automatic logic [VALUE_W-1:0] step_value(input logic [VALUE_W-1:0] v,
		input logic up);
		logic [VALUE_W-1:0] base;
		logic [VALUE_W-1:0] res;
		base = (v > MAX_VALUE) ? '0 : v;
		if (up) begin
			res = (base == MAX_VALUE) ? '0 : base + VALUE_W'(1);
		end else begin
			res = (base == '0) ? MAX_VALUE : base - VALUE_W'(1);
		end
		return res;
	endfunction

	// active-low seven-segment code
	function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'hc0;
			4'd1: s = 8'hf9;
			4'd2: s = 8'ha4;
			4'd3: s = 8'hb0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hf8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = 8'hff;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/akrc_if.sv =====
// Channel interfaces: key samples in, display words out, register writes.
// Depends on akrc_pkg.
interface akrc_key_if import akrc_pkg::*; ();
	logic valid;
	logic ready;
	logic up_pressed;
	logic down_pressed;

	modport source(output valid, up_pressed, down_pressed, input ready);
	modport sink(input valid, up_pressed, down_pressed, output ready);
endinterface

interface akrc_disp_if import akrc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] count_value;
	logic [DIGIT_W-1:0] tens_digit;
	logic [DIGIT_W-1:0] units_digit;
	logic [SEG_W-1:0]   tens_segments;
	logic [SEG_W-1:0]   units_segments;
	logic               stepped;

	modport source(output valid, count_value, tens_digit, units_digit, tens_segments,
		units_segments, stepped, input ready);
	modport sink(input valid, count_value, tens_digit, units_digit, tens_segments,
		units_segments, stepped, output ready);
endinterface

interface akrc_cfg_if import akrc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/akrc_cfg_regs.sv =====
// Configuration registers of the repeat counter.
// Depends on akrc_pkg and akrc_cfg_if.
module akrc_cfg_regs import akrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	akrc_cfg_if.sink   cfg,
	output cfg_t       regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.first_delay  <= FIRST_DELAY_RST;
			regs_q.slow_period  <= SLOW_PERIOD_RST;
			regs_q.slow_repeats <= SLOW_REPEATS_RST;
			regs_q.fast_period  <= FAST_PERIOD_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_FIRST_DELAY:  regs_q.first_delay  <= cfg.data[PERIOD_W-1:0];
				REG_SLOW_PERIOD:  regs_q.slow_period  <= cfg.data[PERIOD_W-1:0];
				REG_SLOW_REPEATS: regs_q.slow_repeats <= cfg.data[REPEATS_W-1:0];
				REG_FAST_PERIOD:  regs_q.fast_period  <= cfg.data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/akrc_repeat_ctrl.sv =====
// Auto-repeat state: value, held flag, repeat countdown, slow repeats left.
// Depends on akrc_pkg.
module akrc_repeat_ctrl import akrc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               up,
	input  logic               down,
	input  cfg_t               regs,
	output logic [VALUE_W-1:0] value_next,
	output logic               stepped_next
);

	logic [VALUE_W-1:0]   value_q;
	logic                 held_q;
	logic [PERIOD_W-1:0]  countdown_q;
	logic [REPEATS_W-1:0] slow_left_q;

	logic                 held_d;
	logic [PERIOD_W-1:0]  countdown_d;
	logic [REPEATS_W-1:0] slow_left_d;

	always_comb begin
		value_next   = value_q;
		stepped_next = 1'b0;
		held_d       = held_q;
		countdown_d  = countdown_q;
		slow_left_d  = slow_left_q;
		if (up || down) begin
			if (!held_q) begin
				value_next   = step_value(value_q, up);
				stepped_next = 1'b1;
				held_d       = 1'b1;
				countdown_d  = countdown_q - PERIOD_W'(1);
				slow_left_d  = regs.slow_repeats;
			end else if (countdown_q == '0) begin
				if (slow_left_q == '0) begin
					countdown_d = regs.fast_period;
				end else begin
					slow_left_d = slow_left_q - REPEATS_W'(1);
					countdown_d = regs.slow_period;
				end
				value_next   = step_value(value_q, up);
				stepped_next = 1'b1;
			end else begin
				countdown_d = countdown_q - PERIOD_W'(1);
			end
		end else begin
			held_d      = 1'b0;
			countdown_d = regs.first_delay;
			slow_left_d = regs.slow_repeats;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q     <= '0;
			held_q      <= 1'b0;
			countdown_q <= SLOW_PERIOD_RST;
			slow_left_q <= SLOW_REPEATS_RST;
		end else if (en) begin
			value_q     <= value_next;
			held_q      <= held_d;
			countdown_q <= countdown_d;
			slow_left_q <= slow_left_d;
		end
	end

endmodule

// ===== rtl/core/akrc_seg_decode.sv =====
// Splits the value into decimal digits and their segment codes.
// Depends on akrc_pkg.
module akrc_seg_decode import akrc_pkg::*; (
	input  logic [VALUE_W-1:0] value,
	output logic [DIGIT_W-1:0] tens,
	output logic [DIGIT_W-1:0] units,
	output logic [SEG_W-1:0]   tens_seg,
	output logic [SEG_W-1:0]   units_seg
);

	logic [VALUE_W-1:0]   v;
	logic [VALUE_W+7:0]   recip;
	logic [VALUE_W-1:0]   tens_x10;
	logic [VALUE_W-1:0]   rem;

	// value mod 100 first, then /10 as *205 >> 11 (exact below 1029)
	assign v        = (value > VALUE_W'(99)) ? value - VALUE_W'(100) : value;
	assign recip    = (VALUE_W+8)'(v) * (VALUE_W+8)'(205);
	assign tens     = recip[14:11];
	assign tens_x10 = VALUE_W'(tens) * VALUE_W'(10);
	assign rem      = v - tens_x10;
	assign units    = rem[DIGIT_W-1:0];

	assign tens_seg  = seg_code(tens);
	assign units_seg = seg_code(units);

endmodule

// ===== rtl/core/accelerating_key_repeat_counter.sv =====
// Accelerating key auto-repeat counter, top level.
// Throughput: one key word per cycle while disp_out is not stalled; input
// register, then state update and decode into the output register.
// Reset: asynchronous, active low; value 0, countdown 100, registers to defaults.
// Depends on akrc_pkg, akrc_if, akrc_cfg_regs, akrc_repeat_ctrl, akrc_seg_decode.
module accelerating_key_repeat_counter import akrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	akrc_key_if.sink    key_in,
	akrc_disp_if.source disp_out,
	akrc_cfg_if.sink    cfg
);

	cfg_t regs;

	logic valid_s1;
	logic up_s1;
	logic down_s1;

	logic               valid_s2;
	logic [VALUE_W-1:0] value_s2;
	logic [DIGIT_W-1:0] tens_s2;
	logic [DIGIT_W-1:0] units_s2;
	logic [SEG_W-1:0]   tens_seg_s2;
	logic [SEG_W-1:0]   units_seg_s2;
	logic               stepped_s2;

	logic               adv_s2;
	logic               adv_s1;
	logic               upd;
	logic [VALUE_W-1:0] value_next;
	logic               stepped_next;
	logic [DIGIT_W-1:0] tens;
	logic [DIGIT_W-1:0] units;
	logic [SEG_W-1:0]   tens_seg;
	logic [SEG_W-1:0]   units_seg;

	assign adv_s2       = !valid_s2 || disp_out.ready;
	assign adv_s1       = !valid_s1 || adv_s2;
	assign upd          = valid_s1 && adv_s2;
	assign key_in.ready = adv_s1;

	akrc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	akrc_repeat_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (upd),
		.up           (up_s1),
		.down         (down_s1),
		.regs         (regs),
		.value_next   (value_next),
		.stepped_next (stepped_next)
	);

	akrc_seg_decode u_dec (
		.value     (value_next),
		.tens      (tens),
		.units     (units),
		.tens_seg  (tens_seg),
		.units_seg (units_seg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= key_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && key_in.valid) begin
			up_s1   <= key_in.up_pressed;
			down_s1 <= key_in.down_pressed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			value_s2     <= value_next;
			tens_s2      <= tens;
			units_s2     <= units;
			tens_seg_s2  <= tens_seg;
			units_seg_s2 <= units_seg;
			stepped_s2   <= stepped_next;
		end
	end

	assign disp_out.valid          = valid_s2;
	assign disp_out.count_value    = value_s2;
	assign disp_out.tens_digit     = tens_s2;
	assign disp_out.units_digit    = units_s2;
	assign disp_out.tens_segments  = tens_seg_s2;
	assign disp_out.units_segments = units_seg_s2;
	assign disp_out.stepped        = stepped_s2;

endmodule

// ===== tb/accelerating_key_repeat_counter_test.sv =====
`timescale 1ns / 1ps
// Testbench for accelerating_key_repeat_counter: key scans in, display words out.
// A directed table, then random presses and noise, checked against a predictor.
// Depends on akrc_pkg, akrc_if and the block itself.
module accelerating_key_repeat_counter_test;
	import akrc_pkg::*;

	localparam int  RESET_CYCLES   = 12;
	localparam int  PHASES         = 8;
	localparam int  PHASE_SCANS    = 210;
	localparam int  HOLDOFF_CYCLES = 64;
	localparam int  HOLDOFF_PHASE  = 0;
	localparam int  DRAIN_PHASE    = 4;
	localparam int  TAIL_CYCLES    = 8;
	localparam int  DIR_ROWS       = 24;
	localparam time RUN_LIMIT      = 2ms;

	localparam logic [PERIOD_W-1:0] COUNTDOWN_RST = PERIOD_W'(100);

	localparam logic [SEG_W-1:0] SEG_LUT [10] = '{8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99,
		8'h92, 8'h82, 8'hf8, 8'h80, 8'h90};

	localparam int SEND_IDLE_PCT [4] = '{0, 58, 0, 19};
	localparam int STALL_PCT [4]     = '{0, 0, 58, 19};

	localparam cfg_t PHASE_CFG [6] = '{
		'{7'd3, 7'd2, 3'd2, 7'd1},
		'{7'd0, 7'd0, 3'd0, 7'd0},
		'{7'd127, 7'd127, 3'd7, 7'd127},
		'{7'd5, 7'd1, 3'd7, 7'd0},
		'{7'd1, 7'd3, 3'd0, 7'd2},
		'{7'd30, 7'd100, 3'd5, 7'd10}
	};

	typedef struct packed {
		logic [VALUE_W-1:0] count_value;
		logic [DIGIT_W-1:0] tens_digit;
		logic [DIGIT_W-1:0] units_digit;
		logic [SEG_W-1:0]   tens_segments;
		logic [SEG_W-1:0]   units_segments;
		logic               stepped;
	} disp_word_t;

	typedef enum logic {ROW_KEY, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic                  up;
		logic                  down;
		cfg_reg_t              idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  pinned;
		logic [VALUE_W-1:0]    value;
		logic                  stepped;
	} stim_row_t;

	// value and stepped are pinned where they follow directly from the sequence
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_KEY, 1'b1, 1'b0, REG_FIRST_DELAY,  7'd0, 1'b1, 7'd1,  1'b1},
		'{ROW_CFG, 1'b0, 1'b0, REG_FIRST_DELAY,  7'd2, 1'b0, 7'd0,  1'b0},
		'{ROW_CFG, 1'b0, 1'b0, REG_SLOW_PERIOD,  7'd1, 1'b0, 7'd0,  1'b0},
		'{ROW_CFG, 1'b0, 1'b0, REG_SLOW_REPEATS, 7'd1, 1'b0, 7'd0,  1'b0},
		'{ROW_CFG, 1'b0, 1'b0, REG_FAST_PERIOD,  7'd0, 1'b0, 7'd0,  1'b0},
		'{ROW_KEY, 1'b0, 1'b0, REG_FIRST_DELAY,  7'd0, 1'b1, 7'd1,  1'b0},
		'{ROW_KEY, 1'b0, 1'b1, REG_FIRST_DELAY,  7'd0, 1'b1, 7'd0,  1'b1},
		'{ROW_KEY, 1'b0, 1'b1, REG_FIRST_DELAY,  7'd0, 1'b1, 7'd0,  1'b0},
		'{ROW_KEY, 1'b0, 1'b1, REG_FIRST_DELAY,  7'd0, 1'b1, 7'd99, 1'b1},
		'{ROW_KEY, 1'b0, 1'b1, REG_FIRST_DELAY,  7'd0, 1'b0, 7'd0,  1'b0},
		'{ROW_KEY, 1'b0, 1'b1, REG_FIRST_DELAY,  7'd0, 1'b1, 7'd98, 1'b1},
		'{ROW_KEY, 1'b0, 1'b1, REG_FIRST_DELAY,  7'd0, 1'b0, 7'd0,  1'b0},
		'{ROW_KEY, 1'b1, 1'b1, REG_FIRST_DELAY,  7'd0, 1'b1, 7'd98, 1'b1},
		'{ROW_KEY, 1'b1, 1'b0, REG_FIRST_DELAY,  7'd0, 1'b0, 7'd0,  1'b0},
		'{ROW_KEY, 1'b1, 1'b0, REG_FIRST_DELAY,  7'd0, 1'b1, 7'd0,  1'b1},
		'{ROW_KEY, 1'b0, 1'b0, REG_FIRST_DELAY,  7'd0, 1'b1, 7'd0,  1'b0},
		'{ROW_KEY, 1'b1, 1'b1, REG_FIRST_DELAY,  7'd0, 1'b1, 7'd1,  1'b1},
		'{ROW_KEY, 1'b0, 1'b0, REG_FIRST_DELAY,  7'd0, 1'b0, 7'd0,  1'b0},
		'{ROW_CFG, 1'b0, 1'b0, REG_FIRST_DELAY,  7'd0, 1'b0, 7'd0,  1'b0},
		'{ROW_KEY, 1'b0, 1'b0, REG_FIRST_DELAY,  7'd0, 1'b0, 7'd0,  1'b0},
		'{ROW_KEY, 1'b1, 1'b0, REG_FIRST_DELAY,  7'd0, 1'b1, 7'd2,  1'b1},
		'{ROW_KEY, 1'b1, 1'b0, REG_FIRST_DELAY,  7'd0, 1'b1, 7'd2,  1'b0},
		'{ROW_KEY, 1'b0, 1'b1, REG_FIRST_DELAY,  7'd0, 1'b0, 7'd0,  1'b0},
		'{ROW_KEY, 1'b0, 1'b0, REG_FIRST_DELAY,  7'd0, 1'b1, 7'd2,  1'b0}
	};

	logic clk;
	logic arst_n;

	akrc_key_if  key_ch();
	akrc_disp_if disp_ch();
	akrc_cfg_if  cfg_ch();

	accelerating_key_repeat_counter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_in  (key_ch),
		.disp_out(disp_ch),
		.cfg     (cfg_ch)
	);

	// predictor state
	cfg_t               cur_cfg;
	logic [VALUE_W-1:0] value_now;
	logic               held;
	logic [PERIOD_W-1:0] countdown;
	logic [REPEATS_W-1:0] slow_left;
	disp_word_t         pending_display [$];

	logic               pinned_valid = 1'b0;
	logic [VALUE_W-1:0] pinned_value = '0;
	logic               pinned_stepped = 1'b0;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int holdoff_token = 0;
	int holdoff_seen = 0;
	int holdoff_left = 0;
	int phase_no = 0;
	int phase_scans = 0;

	int mismatches = 0;
	int scans_accepted = 0;
	int words_checked = 0;
	int steps_seen = 0;
	int regs_written = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#RUN_LIMIT;
		$display("%0t: timeout, %0d display words outstanding", $time, pending_display.size());
		$display("== FAIL ==");
		$finish;
	end

	// output back-pressure, with a single long hold-off
	initial begin
		disp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_token != holdoff_seen) begin
				holdoff_seen = holdoff_token;
				holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				disp_ch.ready <= 1'b0;
			end else begin
				disp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic logic [VALUE_W-1:0] next_value(input logic [VALUE_W-1:0] v,
		input logic up);
		if (up) begin
			return (v >= VALUE_W'(COUNT_MODULUS - 1)) ? '0 : v + VALUE_W'(1);
		end
		return (v == '0) ? VALUE_W'(COUNT_MODULUS - 1) : v - VALUE_W'(1);
	endfunction

	function automatic disp_word_t predict_scan(input logic up, input logic down);
		disp_word_t w;
		logic moved;
		moved = 1'b0;
		if (up || down) begin
			if (!held) begin
				value_now = next_value(value_now, up);
				moved = 1'b1;
				held = 1'b1;
				countdown = countdown - PERIOD_W'(1);
				slow_left = cur_cfg.slow_repeats;
			end else if (countdown == '0) begin
				if (slow_left == '0) begin
					countdown = cur_cfg.fast_period;
				end else begin
					slow_left = slow_left - REPEATS_W'(1);
					countdown = cur_cfg.slow_period;
				end
				value_now = next_value(value_now, up);
				moved = 1'b1;
			end else begin
				countdown = countdown - PERIOD_W'(1);
			end
		end else begin
			held = 1'b0;
			countdown = cur_cfg.first_delay;
			slow_left = cur_cfg.slow_repeats;
		end
		w.count_value = value_now;
		w.tens_digit = DIGIT_W'(value_now / 10);
		w.units_digit = DIGIT_W'(value_now % 10);
		w.tens_segments = SEG_LUT[w.tens_digit];
		w.units_segments = SEG_LUT[w.units_digit];
		w.stepped = moved;
		return w;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		disp_word_t got;
		disp_word_t want;
		if (!arst_n) begin
			cur_cfg = '{FIRST_DELAY_RST, SLOW_PERIOD_RST, SLOW_REPEATS_RST, FAST_PERIOD_RST};
			value_now = '0;
			held = 1'b0;
			countdown = COUNTDOWN_RST;
			slow_left = SLOW_REPEATS_RST;
			pending_display.delete();
		end else begin
			if (disp_ch.valid && disp_ch.ready) begin
				got.count_value = disp_ch.count_value;
				got.tens_digit = disp_ch.tens_digit;
				got.units_digit = disp_ch.units_digit;
				got.tens_segments = disp_ch.tens_segments;
				got.units_segments = disp_ch.units_segments;
				got.stepped = disp_ch.stepped;
				words_checked++;
				if (got.stepped === 1'b1) steps_seen++;
				if (pending_display.size() == 0) begin
					mismatches++;
					$display("%0t: display word with none expected, value %0d", $time,
						got.count_value);
				end else begin
					want = pending_display.pop_front();
					check_field("count_value", want.count_value, got.count_value);
					check_field("tens_digit", want.tens_digit, got.tens_digit);
					check_field("units_digit", want.units_digit, got.units_digit);
					check_field("tens_segments", want.tens_segments, got.tens_segments);
					check_field("units_segments", want.units_segments, got.units_segments);
					check_field("stepped", want.stepped, got.stepped);
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_FIRST_DELAY: cur_cfg.first_delay = cfg_ch.data;
					REG_SLOW_PERIOD: cur_cfg.slow_period = cfg_ch.data;
					REG_SLOW_REPEATS: cur_cfg.slow_repeats = cfg_ch.data[REPEATS_W-1:0];
					REG_FAST_PERIOD: cur_cfg.fast_period = cfg_ch.data;
					default: ;
				endcase
			end
			if (key_ch.valid && key_ch.ready) begin
				want = predict_scan(key_ch.up_pressed, key_ch.down_pressed);
				if (pinned_valid) begin
					want.count_value = pinned_value;
					want.stepped = pinned_stepped;
				end
				pending_display.push_back(want);
				scans_accepted++;
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_key(input logic up, input logic down, input logic pinned = 1'b0,
		input logic [VALUE_W-1:0] value = '0, input logic stepped = 1'b0);
		while ($urandom_range(99) < send_idle_pct) begin
			key_ch.valid <= 1'b0;
			cfg_ch.valid <= 1'b0;
			@(negedge clk);
		end
		key_ch.valid <= 1'b1;
		cfg_ch.valid <= 1'b0;
		key_ch.up_pressed <= up;
		key_ch.down_pressed <= down;
		pinned_valid <= pinned;
		pinned_value <= value;
		pinned_stepped <= stepped;
		do @(posedge clk); while (!key_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		key_ch.valid <= 1'b0;
		cfg_ch.valid <= 1'b0;
		do @(negedge clk); while (pending_display.size() != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		regs_written++;
	endtask

	task automatic scan(input logic up, input logic down);
		send_key(up, down);
		phase_scans++;
		if (phase_no == HOLDOFF_PHASE && phase_scans == 60) holdoff_token <= holdoff_token + 1;
		if (phase_no == DRAIN_PHASE && phase_scans == 100) wait_drained();
	endtask

	initial begin
		cfg_t setting;
		int pick;
		int run_len;
		int long_max;
		logic up;
		logic down;
		arst_n = 1'b0;
		key_ch.valid = 1'b0;
		key_ch.up_pressed = 1'b0;
		key_ch.down_pressed = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_FIRST_DELAY;
		cfg_ch.data = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_drained();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_key(dir_rows[i].up, dir_rows[i].down, dir_rows[i].pinned,
					dir_rows[i].value, dir_rows[i].stepped);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p < 6) begin
				setting = PHASE_CFG[p];
			end else begin
				setting.first_delay = PERIOD_W'($urandom_range(0, 12));
				setting.slow_period = PERIOD_W'($urandom_range(0, 8));
				setting.slow_repeats = REPEATS_W'($urandom_range(0, 7));
				setting.fast_period = PERIOD_W'($urandom_range(0, 4));
			end
			wait_drained();
			write_reg(REG_FIRST_DELAY, setting.first_delay);
			write_reg(REG_SLOW_PERIOD, setting.slow_period);
			// upper data bits are don't-care for the repeat count
			write_reg(REG_SLOW_REPEATS, {4'($urandom), setting.slow_repeats});
			write_reg(REG_FAST_PERIOD, setting.fast_period);
			phase_no = p;
			phase_scans = 0;
			send_idle_pct = SEND_IDLE_PCT[p % 4];
			stall_pct <= STALL_PCT[p % 4];
			long_max = 60 + 2 * int'(setting.first_delay) + int'(setting.slow_period);

			while (phase_scans < PHASE_SCANS) begin
				if ($urandom_range(99) < 75) begin
					pick = $urandom_range(9);
					up = (pick < 4) || (pick >= 8);
					down = (pick >= 4);
					run_len = ($urandom_range(19) == 0) ? $urandom_range(40, long_max)
						: $urandom_range(1, 30);
					for (int k = 0; k < run_len && phase_scans < PHASE_SCANS; k++) begin
						if ($urandom_range(99) < 8) begin
							pick = $urandom_range(9);
							up = (pick < 4) || (pick >= 8);
							down = (pick >= 4);
						end
						scan(up, down);
					end
					run_len = $urandom_range(1, 3);
					for (int k = 0; k < run_len && phase_scans < PHASE_SCANS; k++) begin
						scan(1'b0, 1'b0);
					end
				end else begin
					run_len = $urandom_range(1, 6);
					for (int k = 0; k < run_len && phase_scans < PHASE_SCANS; k++) begin
						scan(1'($urandom_range(1)), 1'($urandom_range(1)));
					end
				end
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_display.size() != 0) begin
			mismatches++;
			$display("%0t: %0d display words never arrived", $time, pending_display.size());
		end
		$display("Sent %0d key scans with %0d register writes over %0d phases.",
			scans_accepted, regs_written, PHASES);
		$display("Checked %0d display words, %0d stepped; %0d mismatches.",
			words_checked, steps_seen, mismatches);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
